// ----- hw/rtl/fse_pkg.sv -----
// Types, constants and arithmetic helpers for the shape function evaluator.
package fse_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int MAX_NODES       = 9;
  localparam int LW              = 21;
  localparam int MW              = 23;
  localparam int TW              = 32;

  localparam logic signed [LW-1:0] ONE = LW'(1 << COORD_FRAC_BITS);

  localparam logic [2:0] KIND_HEX8  = 3'd0;
  localparam logic [2:0] KIND_QUAD4 = 3'd1;
  localparam logic [2:0] KIND_QUAD8 = 3'd2;
  localparam logic [2:0] KIND_QUAD9 = 3'd3;
  localparam logic [2:0] KIND_LINE2 = 3'd4;
  localparam logic [2:0] KIND_LINE3 = 3'd5;

  localparam logic [1:0] POS_NEG = 2'd0;
  localparam logic [1:0] POS_POS = 2'd1;
  localparam logic [1:0] POS_MID = 2'd2;

  localparam logic [1:0] Q9_AX [0:8] = '{POS_NEG, POS_POS, POS_POS, POS_NEG, POS_MID,
                                         POS_POS, POS_MID, POS_NEG, POS_MID};
  localparam logic [1:0] Q9_AY [0:8] = '{POS_NEG, POS_NEG, POS_POS, POS_POS, POS_NEG,
                                         POS_MID, POS_POS, POS_MID, POS_MID};

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
    logic [2:0]         kind;
    logic [3:0]         cnt;
  } item_t;

  typedef struct packed {
    logic signed [LW-1:0] a;
    logic signed [LW-1:0] b;
    logic signed [LW-1:0] c;
    logic signed [LW-1:0] d;
    logic                 m1a;
    logic                 m1c;
    logic                 m2;
    logic                 neg;
    logic [1:0]           k;
  } lane_t;

  typedef struct packed {
    logic signed [MW-1:0] x;
    logic signed [MW-1:0] y;
    logic                 m2;
    logic                 neg;
    logic [1:0]           k;
  } mid_t;

  typedef struct packed {
    logic signed [TW-1:0] t;
    logic                 neg;
    logic [1:0]           k;
  } prod_t;

  typedef struct packed {
    logic signed [LW-1:0] pa;
    logic signed [LW-1:0] pb;
    logic signed [LW-1:0] d;
    logic [1:0]           ps;
    logic [1:0]           ds;
  } lagf_t;

  function automatic logic signed [47:0] rnd_sh(input logic signed [47:0] v,
                                                 input logic [4:0] k);
    logic [47:0] m;
    logic [47:0] r;
    m = v[47] ? 48'(-v) : 48'(v);
    if (k == 5'd0) begin
      r = m;
    end else begin
      r = (m + (48'd1 << (k - 5'd1))) >> k;
    end
    return v[47] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [47:0] fmul(input logic signed [MW-1:0] a,
                                               input logic signed [MW-1:0] b);
    logic signed [2*MW-1:0] p;
    p = a * b;
    return rnd_sh(48'(p), 5'(COORD_FRAC_BITS));
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [47:0] v);
    if (v > 48'sd524287) begin
      return 20'sd524287;
    end else if (v < -48'sd524288) begin
      return -20'sd524288;
    end
    return v[19:0];
  endfunction

  function automatic lagf_t lag1(input logic signed [LW-1:0] c, input logic [1:0] pos);
    lagf_t f;
    case (pos)
      POS_NEG: begin
        f = '{pa: c, pb: c - ONE, d: (c <<< 1) - ONE, ps: 2'd1, ds: 2'd1};
      end
      POS_POS: begin
        f = '{pa: c, pb: c + ONE, d: (c <<< 1) + ONE, ps: 2'd1, ds: 2'd1};
      end
      default: begin
        f = '{pa: ONE - c, pb: ONE + c, d: -(c <<< 1), ps: 2'd0, ds: 2'd0};
      end
    endcase
    return f;
  endfunction

  function automatic logic [3:0] node_count(input logic [2:0] kind);
    logic [3:0] n;
    case (kind)
      KIND_HEX8:  n = 4'd8;
      KIND_QUAD4: n = 4'd4;
      KIND_QUAD8: n = 4'd8;
      KIND_QUAD9: n = 4'd9;
      KIND_LINE2: n = 4'd2;
      KIND_LINE3: n = 4'd3;
      default:    n = 4'd0;
    endcase
    if (n > 4'(MAX_NODES)) begin
      n = 4'(MAX_NODES);
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/fse_if.sv -----
// Point and node result channel interfaces.
interface fse_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] xi_coord;
  logic signed [17:0] eta_coord;
  logic signed [17:0] zeta_coord;
  modport source (output valid, xi_coord, eta_coord, zeta_coord, input ready);
  modport sink (input valid, xi_coord, eta_coord, zeta_coord, output ready);
endinterface

interface fse_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         node_index;
  logic signed [19:0] shape_value;
  logic signed [19:0] deriv_xi;
  logic signed [19:0] deriv_eta;
  logic signed [19:0] deriv_zeta;
  logic               last_node;
  modport source (output valid, node_index, shape_value, deriv_xi, deriv_eta, deriv_zeta,
                  last_node, input ready);
  modport sink (input valid, node_index, shape_value, deriv_xi, deriv_eta, deriv_zeta,
                last_node, output ready);
endinterface

// ----- hw/rtl/fse_front.sv -----
// Front end: element kind register, point intake and two-entry point queue.
module fse_front
  import fse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  fse_in_if.sink     in_ch,
  output logic       q_valid,
  output item_t      q_head,
  input  logic       q_pop
);

  logic [2:0] kind_r;
  item_t      mem_r [0:1];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [3:0] n_nodes;
  logic       push;

  assign n_nodes     = node_count(kind_r);
  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && (n_nodes != 4'd0);
  assign q_valid     = (cnt_r != 2'd0);
  assign q_head      = mem_r[rptr_r];
  assign cnt_nxt     = cnt_r + 2'(push) - 2'(q_pop && q_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_HEX8;
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (cfg_we) begin
        kind_r <= cfg_wdata;
      end
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (q_pop && q_valid) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= '{x: in_ch.xi_coord, y: in_ch.eta_coord, z: in_ch.zeta_coord,
                         kind: kind_r, cnt: n_nodes};
    end
  end

endmodule

// ----- hw/rtl/fse_back.sv -----
// Back end: node sequencer and four-stage evaluation pipeline.
module fse_back
  import fse_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_valid,
  input  item_t  q_head,
  output logic   q_pop,
  fse_out_if.source out_ch
);

  logic [3:0] node_r;
  logic       en, issue, is_last;
  lane_t      ln [0:3];
  lane_t      a_r [0:3];
  mid_t       b_r [0:3];
  prod_t      c_r [0:3];
  logic       va_r, vb_r, vc_r, vo_r;
  logic [3:0] na_r, nb_r, nc_r;
  logic       la_r, lb_r, lc_r;
  logic [3:0] o_node_r;
  logic       o_last_r;
  logic signed [19:0] o_val_r [0:3];

  logic signed [LW-1:0] x, y, z, fx, fy, fz, sxx, syy, fy4, fx5;
  logic                 sxn, syn, szn, syn4, sxn5;
  lagf_t                lx, ly;

  assign en      = !vo_r || out_ch.ready;
  assign issue   = q_valid && en;
  assign is_last = (node_r == q_head.cnt - 4'd1);
  assign q_pop   = issue && is_last;

  always_comb begin
    x    = LW'(q_head.x);
    y    = LW'(q_head.y);
    z    = LW'(q_head.z);
    sxn  = ~(node_r[0] ^ node_r[1]);
    syn  = ~node_r[1];
    szn  = ~node_r[2];
    fx   = sxn ? ONE - x : ONE + x;
    fy   = syn ? ONE - y : ONE + y;
    fz   = szn ? ONE - z : ONE + z;
    sxx  = sxn ? -x : x;
    syy  = syn ? -y : y;
    syn4 = (node_r == 4'd4);
    sxn5 = (node_r == 4'd7);
    fy4  = syn4 ? ONE - y : ONE + y;
    fx5  = sxn5 ? ONE - x : ONE + x;
    lx   = lag1(x, (node_r <= 4'd8) ? Q9_AX[node_r] : POS_MID);
    ly   = lag1(y, (node_r <= 4'd8) ? Q9_AY[node_r] : POS_MID);
    for (int i = 0; i < 4; i++) begin
      ln[i] = '0;
    end
    case (q_head.kind)
      KIND_HEX8: begin
        ln[0] = '{a: fx, b: fy, c: fz, d: '0, m1a: 1'b1, m1c: 1'b0, m2: 1'b1,
                  neg: 1'b0, k: 2'd3};
        ln[1] = '{a: fy, b: fz, c: '0, d: '0, m1a: 1'b1, m1c: 1'b0, m2: 1'b0,
                  neg: sxn, k: 2'd3};
        ln[2] = '{a: fx, b: fz, c: '0, d: '0, m1a: 1'b1, m1c: 1'b0, m2: 1'b0,
                  neg: syn, k: 2'd3};
        ln[3] = '{a: fx, b: fy, c: '0, d: '0, m1a: 1'b1, m1c: 1'b0, m2: 1'b0,
                  neg: szn, k: 2'd3};
      end
      KIND_QUAD4: begin
        ln[0] = '{a: fx, b: fy, c: '0, d: '0, m1a: 1'b1, m1c: 1'b0, m2: 1'b0,
                  neg: 1'b0, k: 2'd2};
        ln[1] = '{a: fy, b: '0, c: '0, d: '0, m1a: 1'b0, m1c: 1'b0, m2: 1'b0,
                  neg: sxn, k: 2'd2};
        ln[2] = '{a: fx, b: '0, c: '0, d: '0, m1a: 1'b0, m1c: 1'b0, m2: 1'b0,
                  neg: syn, k: 2'd2};
      end
      KIND_QUAD8: begin
        if (node_r < 4'd4) begin
          ln[0] = '{a: fx, b: fy, c: sxx + syy - ONE, d: '0, m1a: 1'b1, m1c: 1'b0,
                    m2: 1'b1, neg: 1'b0, k: 2'd2};
          ln[1] = '{a: fy, b: '0, c: (sxx <<< 1) + syy, d: '0, m1a: 1'b0, m1c: 1'b0,
                    m2: 1'b1, neg: sxn, k: 2'd2};
          ln[2] = '{a: fx, b: '0, c: sxx + (syy <<< 1), d: '0, m1a: 1'b0, m1c: 1'b0,
                    m2: 1'b1, neg: syn, k: 2'd2};
        end else if (!node_r[0]) begin
          ln[0] = '{a: ONE - x, b: ONE + x, c: fy4, d: '0, m1a: 1'b1, m1c: 1'b0,
                    m2: 1'b1, neg: 1'b0, k: 2'd1};
          ln[1] = '{a: x, b: '0, c: fy4, d: '0, m1a: 1'b0, m1c: 1'b0,
                    m2: 1'b1, neg: 1'b1, k: 2'd0};
          ln[2] = '{a: ONE - x, b: ONE + x, c: '0, d: '0, m1a: 1'b1, m1c: 1'b0,
                    m2: 1'b0, neg: syn4, k: 2'd1};
        end else begin
          ln[0] = '{a: ONE - y, b: ONE + y, c: fx5, d: '0, m1a: 1'b1, m1c: 1'b0,
                    m2: 1'b1, neg: 1'b0, k: 2'd1};
          ln[1] = '{a: ONE - y, b: ONE + y, c: '0, d: '0, m1a: 1'b1, m1c: 1'b0,
                    m2: 1'b0, neg: sxn5, k: 2'd1};
          ln[2] = '{a: fx5, b: '0, c: y, d: '0, m1a: 1'b0, m1c: 1'b0,
                    m2: 1'b1, neg: 1'b1, k: 2'd0};
        end
      end
      KIND_QUAD9: begin
        ln[0] = '{a: lx.pa, b: lx.pb, c: ly.pa, d: ly.pb, m1a: 1'b1, m1c: 1'b1,
                  m2: 1'b1, neg: 1'b0, k: lx.ps + ly.ps};
        ln[1] = '{a: lx.d, b: '0, c: ly.pa, d: ly.pb, m1a: 1'b0, m1c: 1'b1,
                  m2: 1'b1, neg: 1'b0, k: lx.ds + ly.ps};
        ln[2] = '{a: lx.pa, b: lx.pb, c: ly.d, d: '0, m1a: 1'b1, m1c: 1'b0,
                  m2: 1'b1, neg: 1'b0, k: lx.ps + ly.ds};
      end
      KIND_LINE2: begin
        ln[0] = '{a: node_r[0] ? ONE + x : ONE - x, b: '0, c: '0, d: '0, m1a: 1'b0,
                  m1c: 1'b0, m2: 1'b0, neg: 1'b0, k: 2'd1};
        ln[1] = '{a: ONE, b: '0, c: '0, d: '0, m1a: 1'b0, m1c: 1'b0, m2: 1'b0,
                  neg: !node_r[0], k: 2'd1};
      end
      KIND_LINE3: begin
        ln[0] = '{a: lx.pa, b: lx.pb, c: '0, d: '0, m1a: 1'b1, m1c: 1'b0, m2: 1'b0,
                  neg: 1'b0, k: lx.ps};
        ln[1] = '{a: lx.d, b: '0, c: '0, d: '0, m1a: 1'b0, m1c: 1'b0, m2: 1'b0,
                  neg: 1'b0, k: lx.ds};
        if (node_r == 4'd1) begin
          lx = lag1(x, POS_POS);
        end
      end
      default: begin
      end
    endcase
    if (q_head.kind == KIND_LINE3) begin
      lx = lag1(x, node_r[1:0]);
      ln[0] = '{a: lx.pa, b: lx.pb, c: '0, d: '0, m1a: 1'b1, m1c: 1'b0, m2: 1'b0,
                neg: 1'b0, k: lx.ps};
      ln[1] = '{a: lx.d, b: '0, c: '0, d: '0, m1a: 1'b0, m1c: 1'b0, m2: 1'b0,
                neg: 1'b0, k: lx.ds};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r <= 4'd0;
      va_r   <= 1'b0;
      vb_r   <= 1'b0;
      vc_r   <= 1'b0;
      vo_r   <= 1'b0;
    end else if (en) begin
      va_r <= issue;
      vb_r <= va_r;
      vc_r <= vb_r;
      vo_r <= vc_r;
      if (issue) begin
        node_r <= is_last ? 4'd0 : node_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_r     <= node_r;
      la_r     <= is_last;
      nb_r     <= na_r;
      lb_r     <= la_r;
      nc_r     <= nb_r;
      lc_r     <= lb_r;
      o_node_r <= nc_r;
      o_last_r <= lc_r;
      for (int i = 0; i < 4; i++) begin
        a_r[i]     <= ln[i];
        b_r[i].x   <= a_r[i].m1a ? MW'(fmul(MW'(a_r[i].a), MW'(a_r[i].b)))
                                  : MW'(a_r[i].a);
        b_r[i].y   <= a_r[i].m1c ? MW'(fmul(MW'(a_r[i].c), MW'(a_r[i].d)))
                                  : MW'(a_r[i].c);
        b_r[i].m2  <= a_r[i].m2;
        b_r[i].neg <= a_r[i].neg;
        b_r[i].k   <= a_r[i].k;
        c_r[i].t   <= b_r[i].m2 ? TW'(fmul(b_r[i].x, b_r[i].y)) : TW'(b_r[i].x);
        c_r[i].neg <= b_r[i].neg;
        c_r[i].k   <= b_r[i].k;
        o_val_r[i] <= sat20(c_r[i].neg ? -rnd_sh(48'(c_r[i].t), 5'(c_r[i].k))
                                       : rnd_sh(48'(c_r[i].t), 5'(c_r[i].k)));
      end
    end
  end

  assign out_ch.valid       = vo_r;
  assign out_ch.node_index  = o_node_r;
  assign out_ch.shape_value = o_val_r[0];
  assign out_ch.deriv_xi    = o_val_r[1];
  assign out_ch.deriv_eta   = o_val_r[2];
  assign out_ch.deriv_zeta  = o_val_r[3];
  assign out_ch.last_node   = o_last_r;

  a_mid_item_holds: assert property (@(posedge clk) disable iff (!rst_n)
    node_r != 4'd0 |-> q_valid)
    else $error("node sequencer advanced without a queued point");

  a_node_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> node_r < q_head.cnt)
    else $error("node index past node count");

  a_out_node_cap: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> o_node_r < 4'(MAX_NODES))
    else $error("result node index beyond cap");

  a_pop_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> node_r == 4'd0)
    else $error("sequencer not rewound after last node");

endmodule

// ----- hw/rtl/fem_shape_function_eval.sv -----
// Top level of the isoparametric shape function evaluator.
// Usage:
//   in_ch carries one natural-coordinate point per transfer (xi, eta, zeta,
//   signed, 16 fraction bits). out_ch returns one transfer per element node,
//   in node order, with shape value and the three local derivatives; the
//   final transfer of a point has last_node set.
//   cfg_we/cfg_wdata write the element kind: 0 hex8, 1 quad4, 2 quad8,
//   3 quad9, 4 line2, 5 line3. Kinds 6 and 7 drop the point with no result.
//   Write it only while no point is in flight.
// Timing:
//   A point is held in a queue entry, then each node result passes the a, b,
//   c and output registers. Node results issue one per cycle unless the
//   pipeline stalls, one issue per element node; the node sequencer is the limit.
//   A two-entry point queue lets new points enter while results drain.
// Reset: rst_n (synchronous, low) sets the kind to hex8 and empties the
//   queue and pipeline.
// Stall: while a result waits with out_ch.ready low the whole pipeline
//   holds; the queue keeps accepting until full, then in_ch.ready drops.
module fem_shape_function_eval
  import fse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  fse_in_if.sink     in_ch,
  fse_out_if.source  out_ch
);

  logic  q_valid, q_pop;
  item_t q_head;

  fse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  fse_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
